// ===== rtl/core/mic_pkg.sv =====
// Shared types and constants for the masked interrupt event counter bank.
package mic_pkg;

    localparam int DEF_NUM_SOURCES   = 20;
    localparam int DEF_COUNTER_WIDTH = 32;

    // highest number of sources that can ever count
    localparam int MAX_COUNTERS = 20;

    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [19:0] CLAIM_MASK = 20'hfffff;

    localparam logic [4:0] REG_COUNT_MASK  = 5'd20;
    localparam logic [4:0] REG_NOTIFY_MASK = 5'd21;
    localparam logic [4:0] REG_NOTES       = 5'd22;
    localparam logic [4:0] REG_DUMMY       = 5'd23;
    localparam logic [4:0] REG_LIMIT       = 5'd24;

    localparam logic [1:0] DIR_NONE  = 2'd0;
    localparam logic [1:0] DIR_WRITE = 2'd1;
    localparam logic [1:0] DIR_READ  = 2'd2;
    localparam logic [1:0] DIR_SWAP  = 2'd3;

    localparam logic KIND_EVENT  = 1'b0;
    localparam logic KIND_ACCESS = 1'b1;

    typedef struct packed {
        logic exec;
    } t_dp_cmd;

    typedef struct packed {
        logic        access_error;
        logic [31:0] read_data;
        logic        notify_raised;
        logic [31:0] clear_bits;
        logic        irq_claimed;
    } t_result;

endpackage

// ===== rtl/core/mic_ctrl.sv =====
// Request/result handshake controller for the counter bank.
module mic_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_s_tvalid,
    output logic             o_s_tready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output mic_pkg::t_dp_cmd o_cmd
);
    import mic_pkg::*;

    localparam logic ST_EMPTY = 1'b0;
    localparam logic ST_FULL  = 1'b1;

    logic r_state;
    logic n_state;
    logic accept;

    assign o_s_tready = (r_state == ST_EMPTY) || i_m_tready;
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = (r_state == ST_FULL);
    assign o_cmd.exec = accept;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_EMPTY: begin
                if (accept) begin
                    n_state = ST_FULL;
                end
            end
            ST_FULL: begin
                if (accept) begin
                    n_state = ST_FULL;
                end else if (i_m_tready) begin
                    n_state = ST_EMPTY;
                end
            end
            default: n_state = ST_EMPTY;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_EMPTY;
        end else begin
            r_state <= n_state;
        end
    end

    a_exec_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> o_m_tvalid)
        else $error("result not presented after request");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> o_m_tvalid)
        else $error("stalled result dropped");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |-> !o_cmd.exec)
        else $error("request accepted over a waiting result");

endmodule

// ===== rtl/core/mic_datapath.sv =====
// Counters, mask and note registers, request decode and result register.
module mic_datapath #(
    parameter int NUM_SOURCES   = mic_pkg::DEF_NUM_SOURCES,
    parameter int COUNTER_WIDTH = mic_pkg::DEF_COUNTER_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  mic_pkg::t_dp_cmd               i_cmd,
    input  logic                           i_kind,
    input  logic [mic_pkg::IN_TDATA_W-1:0] i_data,
    output mic_pkg::t_result               o_result
);
    import mic_pkg::*;

    localparam int NCNT   = (NUM_SOURCES < MAX_COUNTERS) ? NUM_SOURCES : MAX_COUNTERS;
    localparam int CIDX_W = (NCNT > 1) ? $clog2(NCNT) : 1;
    localparam logic [5:0] NCNT_V = 6'(NCNT);
    localparam logic [COUNTER_WIDTH-1:0] CTR_ONE = COUNTER_WIDTH'(1);

    logic [COUNTER_WIDTH-1:0] r_ctr [NCNT];
    logic [31:0]              r_count_mask;
    logic [31:0]              r_notify_mask;
    logic [31:0]              r_notes;
    t_result                  r_out;

    logic [31:0]        pending;
    logic [4:0]         reg_index;
    logic [1:0]         access_dir;
    logic [31:0]        write_value;
    logic               is_event;
    logic               claimed;
    logic [31:0]        hits;
    logic [31:0]        note;
    logic               is_ctr;
    logic               err;
    logic               op_ok;
    logic               do_write;
    logic               do_read;
    logic [63:0]        ctr_wide;
    logic [63:0]        wval_wide;
    logic [31:0]        old_value;
    t_result            n_out;

    assign pending     = i_data[31:0];
    assign reg_index   = i_data[36:32];
    assign access_dir  = i_data[38:37];
    assign write_value = i_data[70:39];

    assign is_event = (i_kind == KIND_EVENT);
    assign claimed  = is_event && ((pending[19:0] & CLAIM_MASK) != '0);
    assign hits     = pending & r_count_mask;
    assign note     = pending & r_notify_mask;

    assign is_ctr    = ({1'b0, reg_index} < NCNT_V);
    assign ctr_wide  = 64'(r_ctr[reg_index[CIDX_W-1:0]]);
    assign wval_wide = {32'b0, write_value};

    always_comb begin
        err       = (reg_index >= REG_LIMIT)
                 || ((reg_index != REG_DUMMY) && (access_dir == DIR_NONE));
        op_ok     = !is_event && !err && (reg_index != REG_DUMMY);
        do_write  = op_ok && (access_dir inside {DIR_WRITE, DIR_SWAP});
        do_read   = op_ok && (access_dir inside {DIR_READ, DIR_SWAP});
        case (reg_index)
            REG_COUNT_MASK:  old_value = r_count_mask;
            REG_NOTIFY_MASK: old_value = r_notify_mask;
            REG_NOTES:       old_value = r_notes;
            default:         old_value = is_ctr ? ctr_wide[31:0] : 32'b0;
        endcase

        n_out.irq_claimed   = claimed;
        n_out.clear_bits    = claimed ? pending : 32'b0;
        n_out.notify_raised = claimed && (note != '0);
        n_out.read_data     = do_read ? old_value : 32'b0;
        n_out.access_error  = !is_event && err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NCNT; i++) begin
                r_ctr[i] <= '0;
            end
            r_count_mask  <= '0;
            r_notify_mask <= '0;
            r_notes       <= '0;
        end else if (i_cmd.exec) begin
            if (claimed) begin
                for (int i = 0; i < NCNT; i++) begin
                    if (hits[i]) begin
                        r_ctr[i] <= r_ctr[i] + CTR_ONE;
                    end
                end
                r_notes <= r_notes | note;
            end
            if (do_write) begin
                case (reg_index)
                    REG_COUNT_MASK:  r_count_mask  <= write_value;
                    REG_NOTIFY_MASK: r_notify_mask <= write_value;
                    REG_NOTES:       r_notes       <= write_value;
                    default: begin
                        if (is_ctr) begin
                            r_ctr[reg_index[CIDX_W-1:0]] <= wval_wide[COUNTER_WIDTH-1:0];
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_out <= n_out;
        end
    end

    assign o_result = r_out;

    a_err_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_out.access_error || (r_out.read_data == '0)))
        else $error("error result carries read data");

    a_notify_claimed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.exec |=> (!r_out.notify_raised || r_out.irq_claimed))
        else $error("notify without claim");

    a_unclaimed_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_event && !claimed) |=> (r_notes == $past(r_notes)))
        else $error("unclaimed event changed notes");

    a_event_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && is_event) |=> (!r_out.access_error && (r_out.read_data == '0)))
        else $error("event result carries access fields");

endmodule

// ===== rtl/core/masked_interrupt_event_counters.sv =====
// Top level of the masked interrupt event counter bank.
// One request (an interrupt event or a register access) is taken per clock and its
// result appears in the output register on the next clock; the single output
// register holds it, and a result that is not taken holds off the next request
// until it leaves. Event requests that claim (a pending bit in 19:0) count every
// pending source that the count mask enables, fold pending AND notify mask into the
// sticky notes and return the pending word for clearing; register requests write,
// read or swap counters 0..19, the count mask (20), notify mask (21), notes (22) or
// the dummy (23). Reset clears counters, masks and notes, not the result register.
module masked_interrupt_event_counters #(
    parameter int NUM_SOURCES   = mic_pkg::DEF_NUM_SOURCES,
    parameter int COUNTER_WIDTH = mic_pkg::DEF_COUNTER_WIDTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // pending_bits[31:0], reg_index[36:32], access_dir[38:37], write_value[70:39]
    input  logic [mic_pkg::IN_TDATA_W-1:0]  s_tdata,
    // kind
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // irq_claimed[0], clear_bits[32:1], notify_raised[33], read_data[65:34],
    // access_error[66]
    output logic [mic_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import mic_pkg::*;

    t_dp_cmd cmd;
    t_result result;

    mic_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (cmd)
    );

    mic_datapath #(
        .NUM_SOURCES   (NUM_SOURCES),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_kind   (s_tuser),
        .i_data   (s_tdata),
        .o_result (result)
    );

    assign m_tdata = {5'b0, result};

endmodule

// ===== bench/tb.sv =====
// Testbench for the masked interrupt event counter bank: directed table, then random requests.
`timescale 1ns / 1ps

module tb;
    import mic_pkg::*;

    localparam int NUM_CTRS   = DEF_NUM_SOURCES;
    localparam int STALL_MAX  = 5000;
    localparam int RAND_COUNT = 1900;
    localparam int LONG_HOLD  = 400;

    typedef struct {
        logic        kind;
        logic [31:0] pending;
        logic [4:0]  idx;
        logic [1:0]  dir;
        logic [31:0] wval;
    } t_irq_req;

    typedef struct {
        t_irq_req req;
        bit       typed;
        t_result  want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n  = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   s_tuser  = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    logic [31:0] ctr_val [NUM_CTRS];
    logic [31:0] cnt_mask;
    logic [31:0] ntf_mask;
    logic [31:0] sticky;

    t_result   results_due [$];
    t_stim_row stim_rows [$];
    int        errors;
    int        burst_left;
    int        rand_sent;
    bit        rand_phase;

    masked_interrupt_event_counters dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_result bank_step(input t_irq_req r);
        t_result     res;
        logic [31:0] hits;
        logic [31:0] note;
        logic [31:0] old;
        res = '0;
        if (r.kind == KIND_EVENT) begin
            if ((r.pending[19:0] & CLAIM_MASK) != '0) begin
                hits = r.pending & cnt_mask;
                note = r.pending & ntf_mask;
                for (int i = 0; i < NUM_CTRS; i++) begin
                    if (hits[i]) begin
                        ctr_val[i] = ctr_val[i] + 32'd1;
                    end
                end
                sticky            = sticky | note;
                res.irq_claimed   = 1'b1;
                res.clear_bits    = r.pending;
                res.notify_raised = (note != '0);
            end
        end else if (r.idx >= REG_LIMIT) begin
            res.access_error = 1'b1;
        end else if (r.idx != REG_DUMMY) begin
            case (r.idx)
                REG_COUNT_MASK:  old = cnt_mask;
                REG_NOTIFY_MASK: old = ntf_mask;
                REG_NOTES:       old = sticky;
                default:         old = ctr_val[r.idx];
            endcase
            if (r.dir == DIR_NONE) begin
                res.access_error = 1'b1;
            end else begin
                if (r.dir != DIR_WRITE) begin
                    res.read_data = old;
                end
                if (r.dir != DIR_READ) begin
                    case (r.idx)
                        REG_COUNT_MASK:  cnt_mask = r.wval;
                        REG_NOTIFY_MASK: ntf_mask = r.wval;
                        REG_NOTES:       sticky = r.wval;
                        default:         ctr_val[r.idx] = r.wval;
                    endcase
                end
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("ERROR t=%0t %s: got %h want %h", $realtime, what, got, want);
    endtask

    task automatic add_row(input logic kind, input logic [31:0] pending, input logic [4:0] idx,
                           input logic [1:0] dir, input logic [31:0] wval, input bit typed,
                           input t_result want);
        t_stim_row row;
        row.req   = '{kind, pending, idx, dir, wval};
        row.typed = typed;
        row.want  = want;
        stim_rows.push_back(row);
    endtask

    task automatic send_req(input t_irq_req r, input bit typed, input t_result want);
        t_result res;
        int      gap;
        @(negedge i_clk);
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {1'b0, r.wval, r.dir, r.idx, r.pending};
        do @(posedge i_clk); while (!s_tready);
        res = bank_step(r);
        results_due.push_back(typed ? want : res);
        burst_left--;
        if (burst_left <= 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 4);
            burst_left = $urandom_range(1, 40);
            @(negedge i_clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    function automatic t_irq_req rand_req();
        t_irq_req r;
        r.kind    = 1'($urandom_range(0, 1));
        r.pending = $urandom;
        r.idx     = 5'($urandom_range(0, 31));
        r.dir     = 2'($urandom_range(0, 3));
        r.wval    = $urandom;
        if (r.kind == KIND_EVENT) begin
            case ($urandom_range(0, 7))
                0:       r.pending = r.pending & ~{12'h0, CLAIM_MASK};
                1:       r.pending = 32'h1 << $urandom_range(0, 31);
                2:       r.pending = 32'hffffffff;
                default: ;
            endcase
        end else begin
            if ($urandom_range(0, 99) < 85) begin
                r.idx = 5'($urandom_range(0, 23));
            end
            if ($urandom_range(0, 9) != 0) begin
                r.dir = 2'($urandom_range(1, 3));
            end
            if ($urandom_range(0, 7) == 0) begin
                r.wval = 32'hffffffff - $urandom_range(0, 3);
            end
        end
        return r;
    endfunction

    // receiver: random ready patterns plus one long hold-off
    initial begin
        int  len;
        int  mode;
        bit  long_done;
        long_done = 1'b0;
        forever begin
            if (rand_phase && !long_done && rand_sent >= 300) begin
                long_done = 1'b1;
                repeat (LONG_HOLD) begin
                    @(negedge i_clk);
                    m_tready <= 1'b0;
                end
            end else begin
                len  = $urandom_range(5, 60);
                mode = $urandom_range(0, 3);
                repeat (len) begin
                    @(negedge i_clk);
                    case (mode)
                        0:       m_tready <= 1'b1;
                        1:       m_tready <= 1'($urandom_range(0, 1));
                        2:       m_tready <= ($urandom_range(0, 3) != 0);
                        default: m_tready <= ($urandom_range(0, 3) == 0);
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            got = t_result'(m_tdata[66:0]);
            if (results_due.size() == 0) begin
                report_mismatch("result with no request pending", 32'h0, 32'h0);
            end else begin
                want = results_due.pop_front();
                if (got.irq_claimed !== want.irq_claimed)
                    report_mismatch("irq_claimed", 32'(got.irq_claimed),
                                    32'(want.irq_claimed));
                if (got.clear_bits !== want.clear_bits)
                    report_mismatch("clear_bits", got.clear_bits, want.clear_bits);
                if (got.notify_raised !== want.notify_raised)
                    report_mismatch("notify_raised", 32'(got.notify_raised),
                                    32'(want.notify_raised));
                if (got.read_data !== want.read_data)
                    report_mismatch("read_data", got.read_data, want.read_data);
                if (got.access_error !== want.access_error)
                    report_mismatch("access_error", 32'(got.access_error),
                                    32'(want.access_error));
            end
        end
    end

    initial begin
        int stall;
        stall = 0;
        while (stall < STALL_MAX) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                stall = 0;
            end else begin
                stall++;
            end
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        t_result  none;
        t_result  err;
        t_irq_req r;
        none             = '0;
        err              = '0;
        err.access_error = 1'b1;
        errors           = 0;
        rand_sent        = 0;
        rand_phase       = 1'b0;
        burst_left       = $urandom_range(1, 40);
        for (int i = 0; i < NUM_CTRS; i++) begin
            ctr_val[i] = '0;
        end
        cnt_mask = '0;
        ntf_mask = '0;
        sticky   = '0;

        add_row(KIND_ACCESS, 32'hffffffff, 5'd0, DIR_READ, 32'h0, 1'b1, none);
        add_row(KIND_ACCESS, 32'h0, REG_NOTES, DIR_READ, 32'hffffffff, 1'b1, none);
        add_row(KIND_EVENT, 32'h0, 5'd31, DIR_SWAP, 32'hffffffff, 1'b1, none);
        add_row(KIND_EVENT, 32'hfff00000, 5'd0, DIR_NONE, 32'h0, 1'b1, none);
        add_row(KIND_ACCESS, 32'h0, REG_LIMIT, DIR_READ, 32'h0, 1'b1, err);
        add_row(KIND_ACCESS, 32'h0, 5'd31, DIR_WRITE, 32'hffffffff, 1'b1, err);
        add_row(KIND_ACCESS, 32'h0, 5'd3, DIR_NONE, 32'h12345678, 1'b1, err);
        add_row(KIND_ACCESS, 32'h0, REG_DUMMY, DIR_NONE, 32'h0, 1'b1, none);
        add_row(KIND_ACCESS, 32'h0, REG_DUMMY, DIR_SWAP, 32'hffffffff, 1'b1, none);
        add_row(KIND_ACCESS, 32'h0, REG_COUNT_MASK, DIR_WRITE, 32'hffffffff, 1'b1, none);
        add_row(KIND_ACCESS, 32'h0, REG_NOTIFY_MASK, DIR_WRITE, 32'h00010000, 1'b1, none);
        add_row(KIND_EVENT, 32'hffffffff, 5'd0, DIR_READ, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, REG_NOTES, DIR_SWAP, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, 5'd19, DIR_WRITE, 32'hffffffff, 1'b1, none);
        add_row(KIND_EVENT, 32'h00080000, 5'd0, DIR_NONE, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, 5'd19, DIR_READ, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, 5'd0, DIR_SWAP, 32'hfffffffe, 1'b0, none);
        add_row(KIND_EVENT, 32'h00000001, 5'd0, DIR_NONE, 32'h0, 1'b0, none);
        add_row(KIND_EVENT, 32'h00010001, 5'd0, DIR_NONE, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, 5'd0, DIR_READ, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, REG_COUNT_MASK, DIR_SWAP, 32'h0, 1'b0, none);
        add_row(KIND_EVENT, 32'h000fffff, 5'd0, DIR_NONE, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, REG_NOTIFY_MASK, DIR_READ, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, REG_NOTES, DIR_READ, 32'h0, 1'b0, none);
        add_row(KIND_ACCESS, 32'h0, 5'd7, DIR_READ, 32'h0, 1'b0, none);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            send_req(stim_rows[k].req, stim_rows[k].typed, stim_rows[k].want);
        end

        rand_phase = 1'b1;
        for (rand_sent = 0; rand_sent < RAND_COUNT; rand_sent++) begin
            r = rand_req();
            send_req(r, 1'b0, none);
        end

        @(negedge i_clk);
        s_tvalid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (5) @(posedge i_clk);

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== masked_interrupt_event_counters.f =====
rtl/core/mic_pkg.sv
rtl/core/mic_ctrl.sv
rtl/core/mic_datapath.sv
rtl/core/masked_interrupt_event_counters.sv
bench/tb.sv
